// ----- sv/ezml_pkg.sv -----
`timescale 1ns / 1ps

package ezml_pkg;

  // Default coordinate width and the extra bits the decision value needs.
  localparam int COORD_BITS_DEF = 11;
  localparam int DEC_GUARD      = 5;

  // Operation codes on the command channel.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  // The eight zones, numbered counterclockwise from the shallow +x zone.
  typedef enum logic [2:0] {
    ZONE0 = 3'd0,
    ZONE1 = 3'd1,
    ZONE2 = 3'd2,
    ZONE3 = 3'd3,
    ZONE4 = 3'd4,
    ZONE5 = 3'd5,
    ZONE6 = 3'd6,
    ZONE7 = 3'd7
  } zone_t;

  // True when x is the main axis of the zone.
  function automatic logic main_is_x(zone_t z);
    logic r;
    unique case (z)
      ZONE0, ZONE3, ZONE4, ZONE7: r = 1'b1;
      default:                    r = 1'b0;
    endcase
    return r;
  endfunction

  // Unit x move for a zone, for the diagonal or the straight step.
  function automatic logic signed [1:0] move_x(zone_t z, logic diag);
    logic signed [1:0] r;
    unique case (z)
      ZONE0, ZONE7: r = 2'sd1;
      ZONE1, ZONE6: r = diag ? 2'sd1 : 2'sd0;
      ZONE2, ZONE5: r = diag ? -2'sd1 : 2'sd0;
      default:      r = -2'sd1;
    endcase
    return r;
  endfunction

  // Unit y move for a zone, for the diagonal or the straight step.
  function automatic logic signed [1:0] move_y(zone_t z, logic diag);
    logic signed [1:0] r;
    unique case (z)
      ZONE1, ZONE2: r = 2'sd1;
      ZONE5, ZONE6: r = -2'sd1;
      ZONE0, ZONE3: r = diag ? 2'sd1 : 2'sd0;
      default:      r = diag ? -2'sd1 : 2'sd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/ezml_cmd_if.sv -----
`timescale 1ns / 1ps

interface ezml_cmd_if
  import ezml_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);

  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, operation, start_x, start_y, end_x, end_y, output ready);

endinterface

// ----- sv/ezml_pix_if.sv -----
`timescale 1ns / 1ps

interface ezml_pix_if
  import ezml_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         pixel_valid;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_valid, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_valid, last_pixel, output ready);

endinterface

// ----- sv/eight_zone_midpoint_line_raster_core.sv -----
`timescale 1ns / 1ps

// Midpoint line rasterizer for all eight zones.
// The cmd channel carries one command per transfer: a load with two signed
// endpoints, or a step that asks for the next pixel of the current line.
// Every command transfer yields exactly one transfer on the pix channel.
// A load returns the start pixel; a step returns the next pixel, with
// last_pixel set on the pixel where the main axis reaches the end point.
// A step with no line in progress returns pixel_valid low and zero fields.
// A load always restarts the block, dropping any line in progress.
// The result is registered: it is in the output register on the clock
// edge after the command transfer. Throughput is one command per cycle while
// the receiver takes results, set by the single decision update and compare done per step.
// When the receiver stalls, the output register holds its result and cmd
// ready drops; ready returns in the cycle the result is taken, so no bubble
// is inserted. A synchronous reset clears the line in progress and the
// output valid flag; nothing needs to be swept after reset.
module eight_zone_midpoint_line_raster_core
  import ezml_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ezml_cmd_if.sink   cmd,
  ezml_pix_if.source pix
);

  localparam int DEC_BITS = COORD_BITS + DEC_GUARD;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;

  // Line state.
  logic   busy, busy_next;
  zone_t  zone, zone_next;
  coord_t cur_x, cur_x_next, cur_y, cur_y_next;
  coord_t stop_x, stop_x_next, stop_y, stop_y_next;
  dec_t   decision, decision_next;
  dec_t   inc_straight, inc_straight_next;
  dec_t   inc_diagonal, inc_diagonal_next;

  // Result payload computed for the current command.
  logic   res_valid, res_last;
  coord_t res_x, res_y;

  logic   fire;

  // Load path signals.
  diff_t  dx, dy, ax, ay;
  dec_t   dxw, dyw;
  zone_t  ld_zone;

  // Step path signals.
  logic   diag;

  assign cmd.ready = !pix.valid || pix.ready;
  assign fire      = cmd.valid && cmd.ready;

  // Segment deltas and their magnitudes for zone sorting.
  always_comb begin
    dx  = diff_t'(cmd.end_x) - diff_t'(cmd.start_x);
    dy  = diff_t'(cmd.end_y) - diff_t'(cmd.start_y);
    ax  = dx[COORD_BITS] ? -dx : dx;
    ay  = dy[COORD_BITS] ? -dy : dy;
    dxw = dec_t'(dx);
    dyw = dec_t'(dy);
  end

  // Zone from the delta signs; ties between the magnitudes follow each zone pair.
  always_comb begin
    unique case ({dx[COORD_BITS], dy[COORD_BITS]})
      2'b00:   ld_zone = (ax >= ay) ? ZONE0 : ZONE1;
      2'b10:   ld_zone = (ax <= ay) ? ZONE2 : ZONE3;
      2'b11:   ld_zone = (ax >= ay) ? ZONE4 : ZONE5;
      default: ld_zone = (ax <= ay) ? ZONE6 : ZONE7;
    endcase
  end

  // Odd zones take the diagonal on a negative decision, even zones otherwise.
  assign diag = zone[0] ? decision[DEC_BITS-1] : !decision[DEC_BITS-1];

  // Next line state and the result for this command.
  always_comb begin
    busy_next         = busy;
    zone_next         = zone;
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    stop_x_next       = stop_x;
    stop_y_next       = stop_y;
    decision_next     = decision;
    inc_straight_next = inc_straight;
    inc_diagonal_next = inc_diagonal;
    res_valid         = 1'b0;
    res_last          = 1'b0;
    res_x             = '0;
    res_y             = '0;

    if (op_t'(cmd.operation) == OP_LOAD) begin
      zone_next   = ld_zone;
      cur_x_next  = cmd.start_x;
      cur_y_next  = cmd.start_y;
      stop_x_next = cmd.end_x;
      stop_y_next = cmd.end_y;
      unique case (ld_zone)
        ZONE0: begin
          decision_next     = dec_t'(2 * dyw - dxw);
          inc_straight_next = dec_t'(2 * dyw);
          inc_diagonal_next = dec_t'(2 * (dyw - dxw));
        end
        ZONE1: begin
          decision_next     = dec_t'(dyw - 2 * dxw);
          inc_straight_next = dec_t'(-2 * dxw);
          inc_diagonal_next = dec_t'(2 * (dyw - dxw));
        end
        ZONE2: begin
          decision_next     = dec_t'(-2 * dxw - dyw);
          inc_straight_next = dec_t'(-2 * dxw);
          inc_diagonal_next = dec_t'(-2 * (dyw + dxw));
        end
        ZONE3: begin
          decision_next     = dec_t'(-dxw - 2 * dyw);
          inc_straight_next = dec_t'(-2 * dyw);
          inc_diagonal_next = dec_t'(-2 * (dxw + dyw));
        end
        ZONE4: begin
          decision_next     = dec_t'(dxw - 2 * dyw);
          inc_straight_next = dec_t'(-2 * dyw);
          inc_diagonal_next = dec_t'(2 * (dxw - dyw));
        end
        ZONE5: begin
          decision_next     = dec_t'(2 * dxw - dyw);
          inc_straight_next = dec_t'(2 * dxw);
          inc_diagonal_next = dec_t'(2 * (dxw - dyw));
        end
        ZONE6: begin
          decision_next     = dec_t'(dyw + 2 * dxw);
          inc_straight_next = dec_t'(2 * dxw);
          inc_diagonal_next = dec_t'(2 * (dyw + dxw));
        end
        default: begin
          decision_next     = dec_t'(2 * dyw + dxw);
          inc_straight_next = dec_t'(2 * dyw);
          inc_diagonal_next = dec_t'(2 * (dyw + dxw));
        end
      endcase
      res_last  = main_is_x(ld_zone) ? (cmd.start_x == cmd.end_x)
                                     : (cmd.start_y == cmd.end_y);
      res_valid = 1'b1;
      res_x     = cmd.start_x;
      res_y     = cmd.start_y;
      busy_next = !res_last;
    end else if (busy) begin
      decision_next = decision + (diag ? inc_diagonal : inc_straight);
      cur_x_next    = cur_x + coord_t'(move_x(zone, diag));
      cur_y_next    = cur_y + coord_t'(move_y(zone, diag));
      res_last      = main_is_x(zone) ? (cur_x_next == stop_x) : (cur_y_next == stop_y);
      res_valid     = 1'b1;
      res_x         = cur_x_next;
      res_y         = cur_y_next;
      busy_next     = !res_last;
    end
  end

  // Line state registers; only the control part needs reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      zone <= ZONE0;
    end else if (fire) begin
      busy <= busy_next;
      zone <= zone_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur_x        <= cur_x_next;
      cur_y        <= cur_y_next;
      stop_x       <= stop_x_next;
      stop_y       <= stop_y_next;
      decision     <= decision_next;
      inc_straight <= inc_straight_next;
      inc_diagonal <= inc_diagonal_next;
    end
  end

  // Output register: loaded on every command transfer, held while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (fire) begin
      pix.valid <= 1'b1;
    end else if (pix.ready) begin
      pix.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pix.pixel_x     <= res_x;
      pix.pixel_y     <= res_y;
      pix.pixel_valid <= res_valid;
      pix.last_pixel  <= res_last;
    end
  end

endmodule

// ----- sv/ezml_checker.sv -----
`timescale 1ns / 1ps

module ezml_checker
  import ezml_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         pix_valid,
  input logic                         pix_ready,
  input logic signed [COORD_BITS-1:0] pixel_x,
  input logic signed [COORD_BITS-1:0] pixel_y,
  input logic                         pixel_valid,
  input logic                         last_pixel
);

  // Every command transfer puts a result in the output register next cycle.
  a_cmd_yields_result: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> pix_valid)
    else $error("command transfer without a result on the next cycle");

  // A result only appears after a command transfer.
  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(pix_valid) |-> $past(cmd_valid && cmd_ready))
    else $error("result appeared without a command transfer");

  // Commands are refused only while a result waits on a stalled receiver.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> pix_valid && !pix_ready)
    else $error("command ready low without an output stall");

  // An idle step reports zero fields.
  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0 && !last_pixel)
    else $error("idle step result carries nonzero fields");

  // A stalled result holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_valid) && $stable(last_pixel))
    else $error("stalled result changed");

endmodule

bind eight_zone_midpoint_line_raster_core ezml_checker #(
  .COORD_BITS(COORD_BITS)
) u_ezml_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .pix_valid  (pix.valid),
  .pix_ready  (pix.ready),
  .pixel_x    (pix.pixel_x),
  .pixel_y    (pix.pixel_y),
  .pixel_valid(pix.pixel_valid),
  .last_pixel (pix.last_pixel)
);
